>>> rtl/assert_macros.svh
// Assertion helpers used by the deque RTL.
// Each check is sampled on the rising clock edge and is off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The condition must hold at every clock edge.
`define DEQ_ASSERT(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// When the trigger holds, the result must hold at the next clock edge.
`define DEQ_ASSERT_NEXT(label, trig, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/deq_pkg.sv
package deq_pkg;

    localparam int CAPACITY = 16;
    localparam int DATA_W   = 32;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = $clog2(CAPACITY + 1);

    localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ_FRONT = 3'd4;
    localparam logic [CMD_W-1:0] CMD_READ_BACK  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Row-wide control broadcast to every cell.
    typedef struct packed {
        logic shift_in;   // push at front: every entry moves one cell toward the back
        logic push_back;  // push at back: the first empty cell takes the value
        logic shift_out;  // pop at front: every entry moves one cell toward the front
        logic pop_back;   // pop at back: the last held cell lets go of its entry
    } t_deq_ctl;

endpackage

>>> rtl/double_ended_queue.sv
// A result beat appears on the output in the cycle after its command beat is accepted.
// Throughput: one command per cycle, bound by the single update of the cell row per cycle.
// The input is stalled only while a finished result waits and the output is stalled.
// Reset (synchronous, active low) empties the deque, zeroes the count and drops o_valid.
// Stored values are not cleared by reset; only held entries are ever read.
`include "assert_macros.svh"

module double_ended_queue
    import deq_pkg::*;
(
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [CMD_W-1:0]           i_command,
    input  logic signed [DATA_W-1:0]   i_push_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic [STATUS_W-1:0]        o_status,
    output logic signed [DATA_W-1:0]   o_read_value,
    output logic [CNT_W-1:0]           o_entry_count
);

    // The deque is a row of cells. Cell zero always holds the front entry, and the
    // held cells form an unbroken run from cell zero. A push at the front or a pop
    // at the front moves every entry one cell along; a push or pop at the back
    // touches only the cell at the edge of the run, which each cell finds from its
    // own valid bit and that of its neighbor.

    logic                     accept;
    logic                     full;
    logic                     empty;
    t_deq_ctl                 ctl;

    logic                     cell_valid [CAPACITY];
    logic signed [DATA_W-1:0] cell_data  [CAPACITY];
    logic                     cell_last  [CAPACITY];
    logic signed [DATA_W-1:0] back_value;
    logic [CNT_W-1:0]         held_cells;

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;

    logic                     r_out_valid;
    logic [STATUS_W-1:0]      r_status;
    logic [STATUS_W-1:0]      n_status;
    logic signed [DATA_W-1:0] r_read_value;
    logic signed [DATA_W-1:0] n_read_value;

    // A new command is taken whenever the output register is free or being emptied.
    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign full  = (r_count == CNT_W'(CAPACITY));
    assign empty = (r_count == '0);

    always_comb begin
        ctl.shift_in  = accept && (i_command == CMD_PUSH_FRONT) && !full;
        ctl.push_back = accept && (i_command == CMD_PUSH_BACK)  && !full;
        ctl.shift_out = accept && (i_command == CMD_POP_FRONT)  && !empty;
        ctl.pop_back  = accept && (i_command == CMD_POP_BACK)   && !empty;
    end

    // Cell row. Cell zero sees an always-held left neighbor carrying the pushed
    // value, and the last cell sees an empty right neighbor.
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic                     left_valid;
        logic signed [DATA_W-1:0] left_data;
        logic                     right_valid;
        logic signed [DATA_W-1:0] right_data;

        if (gi == 0) begin : g_head
            assign left_valid = 1'b1;
            assign left_data  = i_push_value;
        end else begin : g_body
            assign left_valid = cell_valid[gi-1];
            assign left_data  = cell_data[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_tail
            assign right_valid = 1'b0;
            assign right_data  = '0;
        end else begin : g_inner
            assign right_valid = cell_valid[gi+1];
            assign right_data  = cell_data[gi+1];
        end

        deq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctl         (ctl),
            .i_push_value  (i_push_value),
            .i_left_valid  (left_valid),
            .i_left_data   (left_data),
            .i_right_valid (right_valid),
            .i_right_data  (right_data),
            .o_valid       (cell_valid[gi]),
            .o_data        (cell_data[gi]),
            .o_last        (cell_last[gi])
        );
    end

    // Exactly one cell flags itself as the back when the deque holds anything,
    // so the back value is an AND-OR over the row.
    always_comb begin
        back_value = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            back_value = back_value | (cell_data[k] & {DATA_W{cell_last[k]}});
        end
    end

    // Status, read data and the next count for the accepted command.
    always_comb begin
        n_status     = ST_OK;
        n_read_value = '0;
        n_count      = r_count;
        unique case (i_command)
            CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                end
            end
            CMD_READ_FRONT: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_read_value = cell_data[0];
                end
            end
            CMD_READ_BACK: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_read_value = back_value;
                end
            end
            default: begin
                // Unused command codes leave everything as it is.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count <= n_count;
            end
            if (accept) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The result beat holds its payload until it is taken.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status     <= n_status;
            r_read_value <= n_read_value;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_status      = r_status;
    assign o_read_value  = r_read_value;
    assign o_entry_count = r_count;

    // Number of cells that hold an entry.
    always_comb begin
        held_cells = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            held_cells = held_cells + CNT_W'(cell_valid[k]);
        end
    end

    // The held cells always number exactly the count.
    `DEQ_ASSERT(a_count_matches_cells, held_cells == r_count, "cell valid bits disagree with the entry count")
    // The front cell is held unless the deque is empty, and the last cell only when it is full.
    `DEQ_ASSERT(a_front_cell_held, cell_valid[0] == !empty, "front cell does not match the empty flag")
    `DEQ_ASSERT(a_tail_cell_full, cell_valid[CAPACITY-1] == full, "last cell does not match the full flag")
    // Every accepted command produces a result beat in the next cycle.
    `DEQ_ASSERT_NEXT(a_result_follows, accept, r_out_valid, "accepted command produced no result beat")

endmodule

>>> rtl/deq_cell.sv
module deq_cell
    import deq_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_deq_ctl                 i_ctl,
    input  logic signed [DATA_W-1:0] i_push_value,
    input  logic                     i_left_valid,
    input  logic signed [DATA_W-1:0] i_left_data,
    input  logic                     i_right_valid,
    input  logic signed [DATA_W-1:0] i_right_data,
    output logic                     o_valid,
    output logic signed [DATA_W-1:0] o_data,
    output logic                     o_last
);

    logic                     r_valid;
    logic                     n_valid;
    logic signed [DATA_W-1:0] r_data;
    logic signed [DATA_W-1:0] n_data;

    // At most one control bit is set in a cycle, and in an idle cycle none is.
    always_comb begin
        n_valid = r_valid;
        n_data  = r_data;
        if (i_ctl.shift_in) begin
            n_valid = i_left_valid;
            n_data  = i_left_data;
        end else if (i_ctl.shift_out) begin
            n_valid = i_right_valid;
            n_data  = i_right_data;
        end else if (i_ctl.push_back) begin
            // Only the first empty cell behind a held one takes the value.
            if (!r_valid && i_left_valid) begin
                n_valid = 1'b1;
                n_data  = i_push_value;
            end
        end else if (i_ctl.pop_back) begin
            if (r_valid && !i_right_valid) begin
                n_valid = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
    assign o_last  = r_valid && !i_right_valid;

endmodule
